// ----- design/linear_probe_hash_set_unit_assert.svh -----
// Assertion macros for the linear probe hash set unit checks
`ifndef LINEAR_PROBE_HASH_SET_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPHS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LPHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lphs_pkg.sv -----
// Types and constants shared by the linear probe hash set unit
`default_nettype none
package lphs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_BITS_DEF    = 64;
    localparam int KEY_W           = 64;
    localparam int HOME_W          = 10;
    localparam int CAP_W           = 11;
    localparam int CAP_RESET       = 1024;
    localparam int MARK_W          = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_INSERTED = 3'd0,
        STAT_DUP      = 3'd1,
        STAT_NOROOM   = 3'd2,
        STAT_ERASED   = 3'd3,
        STAT_NOTFOUND = 3'd4,
        STAT_CLEARED  = 3'd5,
        STAT_BAD      = 3'd6
    } status_t;

    typedef enum logic [MARK_W-1:0] {
        MARK_EMPTY = 2'd0,
        MARK_FULL  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PROBE
    } lphs_state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
        logic [HOME_W-1:0] home_slot;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [HOME_W-1:0] slot_index;
        logic [CAP_W-1:0]  filled_count;
    } rsp_t;

endpackage
`default_nettype wire

// ----- design/lphs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
`default_nettype none
module lphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/linear_probe_hash_set_unit.sv -----
// Insert or erase items probe from the home slot until a hit, an empty slot or the last slot, then strobe done.
// Bad slot, bad command and table-full items strobe done in the cycle after acceptance.
// Insert, erase and clear items keep busy high until they finish; rejected items never raise busy.
// Clear and capacity writes sweep the slots in use, one per cycle, with busy high.
// Reset: asynchronous; sweeps min(1024, TABLE_DEPTH) slots with busy high before first item.
// Results carry a one-cycle done strobe and cannot be held off.
`default_nettype none
module linear_probe_hash_set_unit #(
    parameter int TABLE_DEPTH = lphs_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = lphs_pkg::KEY_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire lphs_pkg::req_t              req,
    output logic                             done,
    output lphs_pkg::rsp_t                   rsp,
    input  wire logic                        cfg_we,
    input  wire logic [lphs_pkg::CAP_W-1:0]  cfg_wdata
);
    import lphs_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_W     = KEY_BITS + MARK_W;
    localparam int RESET_CAP = (CAP_RESET > TABLE_DEPTH) ? TABLE_DEPTH : CAP_RESET;
    localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);

    lphs_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     cap_reg, cap_next;
    logic [CAP_W-1:0]     live_reg, live_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic                 report_reg, report_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 accept;
    logic [CNT_W-1:0]     cfg_cap;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [RAM_W-1:0]     ram_rdata;
    mark_t                rd_mark;
    logic [KEY_BITS-1:0]  rd_key;
    logic                 hit;
    logic                 empty;
    logic [CNT_W-1:0]     idx_inc;
    logic [IDX_W-1:0]     idx_wrap;
    logic                 cnt_last;
    logic                 home_bad;
    logic                 table_full;

    lphs_ram #(
        .WIDTH(RAM_W),
        .DEPTH(TABLE_DEPTH)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign done       = done_reg;
    assign rsp        = rsp_reg;

    assign rd_mark    = mark_t'(ram_rdata[RAM_W-1 -: MARK_W]);
    assign rd_key     = ram_rdata[KEY_BITS-1:0];
    assign hit        = (rd_mark == MARK_FULL) && (rd_key == key_reg);
    assign empty      = (rd_mark == MARK_EMPTY);
    assign idx_inc    = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_wrap   = (idx_inc >= cap_reg) ? '0 : IDX_W'(idx_inc);
    assign cnt_last   = (CNT_W'(cnt_reg + CNT_W'(1)) == cap_reg);
    assign home_bad   = (32'(req.home_slot) >= 32'(cap_reg));
    assign table_full = (32'(live_reg) >= 32'(cap_reg));

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_cap = CNT_W'(1);
        end
        else if (32'(cfg_wdata) > DEPTH_U)
        begin
            cfg_cap = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            cfg_cap = CNT_W'(cfg_wdata);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = ST_CLEAR;
                end
                else if (accept)
                begin
                    unique case (req.cmd)
                        CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        CMD_INSERT:
                        begin
                            if (!home_bad && !table_full)
                            begin
                                state_next = ST_PROBE;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (!home_bad)
                            begin
                                state_next = ST_PROBE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (!cfg_we && cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                if (hit || empty || cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cap_next    = cap_reg;
        live_next   = live_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        report_next = report_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = {MARK_FULL, key_reg};
        ram_raddr   = IDX_W'(req.home_slot);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    cap_next    = cfg_cap;
                    live_next   = '0;
                    cnt_next    = '0;
                    report_next = 1'b0;
                end
                else if (accept)
                begin
                    cmd_next              = req.cmd;
                    key_next              = req.key[KEY_BITS-1:0];
                    idx_next              = IDX_W'(req.home_slot);
                    cnt_next              = '0;
                    rsp_next.slot_index   = '0;
                    rsp_next.filled_count = live_reg;
                    unique case (req.cmd)
                        CMD_CLEAR:
                        begin
                            live_next   = '0;
                            report_next = 1'b1;
                        end
                        CMD_INSERT:
                        begin
                            if (home_bad)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_BAD;
                            end
                            else if (table_full)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_NOROOM;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (home_bad)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_BAD;
                            end
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = STAT_BAD;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(cnt_reg);
                ram_wdata = '0;
                if (cfg_we)
                begin
                    cap_next    = cfg_cap;
                    live_next   = '0;
                    cnt_next    = '0;
                    report_next = 1'b0;
                end
                else if (cnt_last)
                begin
                    cnt_next    = '0;
                    report_next = 1'b0;
                    if (report_reg)
                    begin
                        done_next             = 1'b1;
                        rsp_next.status       = STAT_CLEARED;
                        rsp_next.slot_index   = '0;
                        rsp_next.filled_count = '0;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_PROBE:
            begin
                ram_raddr             = idx_wrap;
                rsp_next.slot_index   = '0;
                rsp_next.filled_count = live_reg;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (empty)
                    begin
                        ram_we                = 1'b1;
                        ram_wdata             = {MARK_FULL, key_reg};
                        live_next             = live_reg + CAP_W'(1);
                        done_next             = 1'b1;
                        rsp_next.status       = STAT_INSERTED;
                        rsp_next.slot_index   = HOME_W'(idx_reg);
                        rsp_next.filled_count = live_reg + CAP_W'(1);
                    end
                    else if (hit)
                    begin
                        done_next           = 1'b1;
                        rsp_next.status     = STAT_DUP;
                        rsp_next.slot_index = HOME_W'(idx_reg);
                    end
                    else if (cnt_last)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = STAT_NOROOM;
                    end
                    else
                    begin
                        idx_next = idx_wrap;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        ram_we                = 1'b1;
                        ram_wdata             = {MARK_TOMB, rd_key};
                        live_next             = live_reg - CAP_W'(1);
                        done_next             = 1'b1;
                        rsp_next.status       = STAT_ERASED;
                        rsp_next.slot_index   = HOME_W'(idx_reg);
                        rsp_next.filled_count = live_reg - CAP_W'(1);
                    end
                    else if (empty || cnt_last)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = STAT_NOTFOUND;
                    end
                    else
                    begin
                        idx_next = idx_wrap;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cap_reg    <= CNT_W'(RESET_CAP);
            live_reg   <= '0;
            cnt_reg    <= '0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cap_reg    <= cap_next;
            live_reg   <= live_next;
            cnt_reg    <= cnt_next;
            report_reg <= report_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

endmodule
`default_nettype wire

// ----- design/lphs_checker.sv -----
// Port-level checks for the linear probe hash set unit, bound to the top level
`default_nettype none
`include "linear_probe_hash_set_unit_assert.svh"
module lphs_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire lphs_pkg::req_t              req,
    input wire logic                        done,
    input wire lphs_pkg::rsp_t              rsp,
    input wire logic                        cfg_we,
    input wire logic [lphs_pkg::CAP_W-1:0]  cfg_wdata
);
    import lphs_pkg::*;

    logic acc_clean;

    assign acc_clean = start && !busy && !cfg_we && (cfg_wdata == cfg_wdata);

    `LPHS_ASSERT_NEXT(a_clear_sweeps, acc_clean && req.cmd == CMD_CLEAR, busy, "clear item did not start a sweep")
    `LPHS_ASSERT_NEXT(a_bad_cmd, acc_clean && req.cmd != CMD_INSERT && req.cmd != CMD_ERASE && req.cmd != CMD_CLEAR, done && rsp.status == STAT_BAD, "unknown command not rejected")
    `LPHS_ASSERT_IMP(a_cleared_zero, done && rsp.status == STAT_CLEARED, rsp.filled_count == '0 && rsp.slot_index == '0, "cleared item reports live keys")
    `LPHS_ASSERT_IMP(a_miss_slot, done && (rsp.status == STAT_NOROOM || rsp.status == STAT_NOTFOUND || rsp.status == STAT_BAD), rsp.slot_index == '0, "slot index set without a slot")
    `LPHS_ASSERT_NEXT(a_cfg_sweeps, cfg_we && !busy, busy, "capacity write did not clear the table")

endmodule

bind linear_probe_hash_set_unit lphs_checker u_lphs_checker (.*);
`default_nettype wire

// ----- bench/tb_linear_probe_hash_set_unit.sv -----
// Testbench for the linear probe hash set unit: directed and random items checked against a model
`timescale 1ns / 100ps
module tb_linear_probe_hash_set_unit;
    import lphs_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 5000000;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic done;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    mark_t slot_state [TABLE_DEPTH_DEF];
    logic [KEY_W-1:0] slot_value [TABLE_DEPTH_DEF];
    int unsigned keys_held;
    int unsigned slots_in_use;

    rsp_t pending_results [$];
    rsp_t oldest_result;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit quiet = 1'b0;

    linear_probe_hash_set_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void empty_table();
        for (int i = 0; i < TABLE_DEPTH_DEF; i++)
        begin
            slot_state[i] = MARK_EMPTY;
            slot_value[i] = '0;
        end
        keys_held = 0;
    endfunction

    function automatic int unsigned next_slot(input int unsigned idx);
        return (idx + 1 >= slots_in_use) ? 0 : idx + 1;
    endfunction

    function automatic rsp_t apply_to_table(input req_t r);
        rsp_t o;
        int unsigned idx;
        logic [1:0] c;
        o.status = STAT_BAD;
        o.slot_index = '0;
        c = r.cmd;
        idx = 32'(r.home_slot);
        if (c == CMD_CLEAR)
        begin
            empty_table();
            o.status = STAT_CLEARED;
        end
        else if (c == CMD_UNKNOWN || idx >= slots_in_use)
        begin
            o.status = STAT_BAD;
        end
        else if (c == CMD_INSERT)
        begin
            o.status = STAT_NOROOM;
            if (keys_held < slots_in_use)
            begin
                for (int unsigned n = 0; n < slots_in_use; n++)
                begin
                    if (slot_state[idx] == MARK_EMPTY)
                    begin
                        slot_state[idx] = MARK_FULL;
                        slot_value[idx] = r.key;
                        keys_held++;
                        o.status = STAT_INSERTED;
                        o.slot_index = idx[HOME_W-1:0];
                        break;
                    end
                    if (slot_state[idx] == MARK_FULL && slot_value[idx] == r.key)
                    begin
                        o.status = STAT_DUP;
                        o.slot_index = idx[HOME_W-1:0];
                        break;
                    end
                    idx = next_slot(idx);
                end
            end
        end
        else
        begin
            o.status = STAT_NOTFOUND;
            for (int unsigned n = 0; n < slots_in_use; n++)
            begin
                if (slot_state[idx] == MARK_FULL && slot_value[idx] == r.key)
                begin
                    slot_state[idx] = MARK_TOMB;
                    keys_held--;
                    o.status = STAT_ERASED;
                    o.slot_index = idx[HOME_W-1:0];
                    break;
                end
                if (slot_state[idx] == MARK_EMPTY)
                    break;
                idx = next_slot(idx);
            end
        end
        o.filled_count = keys_held[CAP_W-1:0];
        return o;
    endfunction

    function automatic req_t make_req(input logic [1:0] c, input logic [KEY_W-1:0] k,
                                      input logic [HOME_W-1:0] h);
        req_t r;
        r.cmd = cmd_t'(c);
        r.key = k;
        r.home_slot = h;
        return r;
    endfunction

    task automatic send_item(input req_t r);
        rsp_t expected;
        while (!quiet && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        expected = apply_to_table(r);
        pending_results.insert(pending_results.size(), expected);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (value == 0)
            slots_in_use = 1;
        else if (value > TABLE_DEPTH_DEF)
            slots_in_use = TABLE_DEPTH_DEF;
        else
            slots_in_use = 32'(value);
        empty_table();
    endtask

    task automatic test_extreme_keys();
        send_item(make_req(CMD_INSERT, 64'h0, 10'd0));
        send_item(make_req(CMD_INSERT, '1, 10'd1023));
        send_item(make_req(CMD_INSERT, 64'h0, 10'd0));
        send_item(make_req(CMD_INSERT, 64'h8000_0000_0000_0001, 10'd1023));
        send_item(make_req(CMD_ERASE, '1, 10'd1023));
        send_item(make_req(CMD_ERASE, '1, 10'd1023));
        send_item(make_req(CMD_UNKNOWN, '1, 10'd5));
        send_item(make_req(CMD_CLEAR, 64'h1234_5678_9abc_def0, 10'd77));
    endtask

    task automatic test_probe_wrap_and_full();
        write_capacity(11'd4);
        send_item(make_req(CMD_INSERT, 64'hA, 10'd3));
        send_item(make_req(CMD_INSERT, 64'hB, 10'd3));
        send_item(make_req(CMD_INSERT, 64'hC, 10'd3));
        send_item(make_req(CMD_INSERT, 64'hD, 10'd3));
        send_item(make_req(CMD_INSERT, 64'hE, 10'd3));
        send_item(make_req(CMD_INSERT, 64'hE, 10'd4));
        send_item(make_req(CMD_ERASE, 64'hB, 10'd3));
        send_item(make_req(CMD_INSERT, 64'hE, 10'd3));
        send_item(make_req(CMD_ERASE, 64'hE, 10'd0));
        send_item(make_req(CMD_ERASE, 64'hC, 10'd1023));
        send_item(make_req(CMD_CLEAR, 64'h0, 10'd0));
    endtask

    task automatic test_capacity_limits();
        write_capacity(11'd0);
        send_item(make_req(CMD_INSERT, 64'h55, 10'd0));
        send_item(make_req(CMD_INSERT, 64'h66, 10'd1));
        send_item(make_req(CMD_INSERT, 64'h66, 10'd0));
        send_item(make_req(CMD_ERASE, 64'h55, 10'd0));
        send_item(make_req(CMD_ERASE, 64'h55, 10'd0));
        write_capacity(11'd2047);
        send_item(make_req(CMD_INSERT, 64'h77, 10'd1023));
        send_item(make_req(CMD_INSERT, 64'h78, 10'd1023));
        write_capacity(11'd1024);
        send_item(make_req(CMD_ERASE, 64'h77, 10'd1023));
    endtask

    task automatic run_random_phase(input logic [CAP_W-1:0] cap_value, input int unsigned n_items,
                                    input bit no_idle);
        logic [KEY_W-1:0] pool_key [24];
        logic [HOME_W-1:0] pool_home [24];
        int unsigned pool_n;
        int unsigned base;
        int unsigned pick;
        int unsigned roll;
        logic [1:0] c;
        logic [KEY_W-1:0] k;
        logic [HOME_W-1:0] h;
        write_capacity(cap_value);
        quiet = no_idle;
        pool_n = (slots_in_use + 4 < 24) ? slots_in_use + 4 : 24;
        base = (slots_in_use > 4) ? slots_in_use - 4 : 0;
        for (int i = 0; i < 24; i++)
        begin
            pool_key[i] = {$urandom, $urandom};
            pool_home[i] = HOME_W'((base + $urandom_range(7)) % slots_in_use);
        end
        repeat (n_items)
        begin
            roll = $urandom_range(99);
            pick = $urandom_range(pool_n - 1);
            k = pool_key[pick];
            h = pool_home[pick];
            if (roll < 50)
                c = CMD_INSERT;
            else if (roll < 88)
                c = CMD_ERASE;
            else if (roll < 91)
            begin
                c = CMD_CLEAR;
                k = {$urandom, $urandom};
                h = HOME_W'($urandom_range(1023));
            end
            else if (roll < 93)
                c = CMD_UNKNOWN;
            else
            begin
                c = $urandom_range(1) ? CMD_INSERT : CMD_ERASE;
                k = {$urandom, $urandom};
                h = HOME_W'($urandom_range(1023));
            end
            send_item(make_req(c, k, h));
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(11'd16, 75, 1'b0);
        run_random_phase(11'd5, 75, 1'b0);
        run_random_phase(11'd1024, 75, 1'b0);
        run_random_phase(11'd64, 75, 1'b1);
        run_random_phase(11'd3, 75, 1'b0);
        run_random_phase(11'd1, 70, 1'b0);
        run_random_phase(11'd300, 75, 1'b0);
        run_random_phase(11'd2047, 70, 1'b0);
        run_random_phase(11'd0, 60, 1'b0);
        run_random_phase(11'd128, 75, 1'b0);
        run_random_phase(11'd2, 75, 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none pending: status %0d slot %0d count %0d",
                         $time, rsp.status, rsp.slot_index, rsp.filled_count);
                mismatches++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp.status !== oldest_result.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_result.status, rsp.status);
                    mismatches++;
                end
                if (rsp.slot_index !== oldest_result.slot_index)
                begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, oldest_result.slot_index, rsp.slot_index);
                    mismatches++;
                end
                if (rsp.filled_count !== oldest_result.filled_count)
                begin
                    $display("%0t: filled_count expected %0d actual %0d",
                             $time, oldest_result.filled_count, rsp.filled_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_linear_probe_hash_set_unit failed");
            $finish;
        end
    end

    initial
    begin
        slots_in_use = CAP_RESET;
        empty_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_keys();
        test_probe_wrap_and_full();
        test_capacity_limits();
        test_random_traffic();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_linear_probe_hash_set_unit passed");
        else
            $display("tb_linear_probe_hash_set_unit failed");
        $finish;
    end

endmodule
